### src/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse core.
package mi3_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ENT_W      = 32;
    localparam int NENT       = 9;
    localparam int PROD_W     = 2 * ENT_W;
    localparam int COF_W      = PROD_W + 1;
    localparam int DET_W      = COF_W + ENT_W + 2;
    localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
    localparam int DEN_W      = DET_W;
    localparam int QB         = ENT_W + 2;
    localparam int CMP_W      = DEN_W + QB;
    localparam int LANE_LAT   = QB + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int DATA_W     = NENT * ENT_W;

    localparam logic [ENT_W-1:0] ONE_VAL = ENT_W'(64'd1 << FRAC_BITS);
    localparam logic [ENT_W-1:0] POS_MAX = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic [ENT_W-1:0] NEG_MIN = {1'b1, {(ENT_W-1){1'b0}}};

    // cofactor i = e[p0]*e[p1] - e[p2]*e[p3], entries row by row
    localparam int COF_PAIR [NENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic signed [ENT_W-1:0] ent_t;
    typedef logic signed [COF_W-1:0] cof_t;
    typedef logic signed [DET_W-1:0] det_t;

    typedef struct packed {
        cof_t [NENT-1:0] cof;
        det_t            det;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### src/mi3_front.sv
// Front end: accepts matrices, forms cofactors and determinant.
module mi3_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mi3_pkg::DATA_W-1:0]   in_data,
    input  mi3_pkg::fifo_stat_t          fstat,
    output logic                         push,
    output mi3_pkg::job_t                job
);

    localparam int NE = mi3_pkg::NENT;
    localparam int EW = mi3_pkg::ENT_W;
    localparam int PW = mi3_pkg::PROD_W;
    localparam int CW = mi3_pkg::COF_W;
    localparam int DW = mi3_pkg::DET_W;
    localparam int TW = CW + EW;

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic       en;

    logic signed [PW-1:0] prod_reg [2*NE];
    mi3_pkg::ent_t        ar1_reg  [3];
    mi3_pkg::ent_t        ar2_reg  [3];
    mi3_pkg::cof_t        cof2_reg [NE];
    mi3_pkg::cof_t        cof3_reg [NE];
    logic signed [EW+1+EW:0] plo_reg [3];
    logic signed [EW+1+EW:0] phi_reg [3];
    mi3_pkg::det_t        det_reg;
    mi3_pkg::cof_t        cof4_reg [NE];

    mi3_pkg::ent_t        ent [NE];
    logic signed [TW-1:0] term [3];

    assign en       = !vld_reg[3] || !fstat.full;
    assign in_ready = en;
    assign push     = vld_reg[3] && !fstat.full;

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            ent[i] = in_data[i*EW +: EW];
        end
        for (int k = 0; k < 3; k++)
        begin
            term[k] = (TW'(phi_reg[k]) <<< EW) + TW'(plo_reg[k]);
        end
        vld_next = {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NE; i++)
            begin
                prod_reg[2*i]   <= ent[mi3_pkg::COF_PAIR[i][0]] * ent[mi3_pkg::COF_PAIR[i][1]];
                prod_reg[2*i+1] <= ent[mi3_pkg::COF_PAIR[i][2]] * ent[mi3_pkg::COF_PAIR[i][3]];
                cof2_reg[i] <= CW'(prod_reg[2*i]) - CW'(prod_reg[2*i+1]);
                cof3_reg[i] <= cof2_reg[i];
                cof4_reg[i] <= cof3_reg[i];
            end
            for (int k = 0; k < 3; k++)
            begin
                ar1_reg[k] <= ent[k];
                ar2_reg[k] <= ar1_reg[k];
                // row 0 expansion uses cofactors 0, 3, 6
                plo_reg[k] <= ar2_reg[k] * $signed({2'b00, cof2_reg[3*k][EW-1:0]});
                phi_reg[k] <= ar2_reg[k] * $signed(cof2_reg[3*k][CW-1:EW]);
            end
            det_reg <= DW'(term[0]) + DW'(term[1]) + DW'(term[2]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            job.cof[i] = cof4_reg[i];
        end
        job.det = det_reg;
    end

endmodule

### src/mi3_fifo.sv
// Short request queue between front and back.
module mi3_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mi3_pkg::job_t        wdata,
    input  logic                 pop,
    output mi3_pkg::job_t        rdata,
    output mi3_pkg::fifo_stat_t  fstat
);

    localparam int AW = mi3_pkg::FIFO_AW;

    mi3_pkg::job_t   mem [mi3_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     cnt_reg;
    logic            do_pop;

    assign fstat.full  = (cnt_reg == (AW+1)'(mi3_pkg::FIFO_DEPTH));
    assign fstat.empty = (cnt_reg == '0);
    assign do_pop      = pop && !fstat.empty;
    assign rdata       = mem[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        assert (!(push && fstat.full && !do_pop))
        else $error("queue written while full");
    end

    property p_cnt_track;
        @(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1);
    endproperty
    a_cnt_track: assert property (p_cnt_track) else $error("queue count slip");

    property p_bound;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(mi3_pkg::FIFO_DEPTH);
    endproperty
    a_bound: assert property (p_bound) else $error("queue count overflow");

endmodule

### src/mi3_div_lane.sv
// Pipelined restoring divider lane with rounding and saturation.
module mi3_div_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mi3_pkg::NUM_W-1:0]   num,
    input  logic [mi3_pkg::DEN_W-1:0]   den,
    input  logic                        neg,
    output logic [mi3_pkg::ENT_W-1:0]   quo
);

    localparam int QB = mi3_pkg::QB;
    localparam int DW = mi3_pkg::DEN_W;
    localparam int CW = mi3_pkg::CMP_W;
    localparam int EW = mi3_pkg::ENT_W;

    logic [CW-1:0] rem_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];

    logic [QB:0]   qr;
    logic          rnd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QB);
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int B = QB - 1 - s;
        logic [CW-1:0] dsh;
        logic          ge;
        assign dsh = CW'(d_reg[s]) << B;
        assign ge  = rem_reg[s] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? rem_reg[s] - dsh : rem_reg[s];
                q_reg[s+1]   <= q_reg[s] | (QB'(ge) << B);
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign rnd = {rem_reg[QB][DW-1:0], 1'b0} >= {1'b0, d_reg[QB]};
    assign qr  = {1'b0, q_reg[QB]} + (QB+1)'(rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!neg_reg[QB])
            begin
                quo <= (ovf_reg[QB] || qr > (QB+1)'(mi3_pkg::POS_MAX))
                       ? mi3_pkg::POS_MAX : qr[EW-1:0];
            end
            else
            begin
                quo <= (ovf_reg[QB] || qr > (QB+1)'(mi3_pkg::NEG_MIN))
                       ? mi3_pkg::NEG_MIN : EW'(0) - qr[EW-1:0];
            end
        end
    end

endmodule

### src/mi3_back.sv
// Back end: sign split, nine divider lanes, singular override.
module mi3_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mi3_pkg::job_t                job,
    input  mi3_pkg::fifo_stat_t          fstat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mi3_pkg::DATA_W-1:0]   out_data,
    output logic                         out_sing
);

    localparam int NE  = mi3_pkg::NENT;
    localparam int EW  = mi3_pkg::ENT_W;
    localparam int CW  = mi3_pkg::COF_W;
    localparam int LAT = mi3_pkg::LANE_LAT;
    localparam int F2  = 2 * mi3_pkg::FRAC_BITS;

    logic                       en;
    logic [LAT:0]               vld_reg;
    logic [LAT:0]               sing_reg;
    logic [mi3_pkg::NUM_W-1:0]  n_reg   [NE];
    logic                       neg_reg [NE];
    logic [mi3_pkg::DEN_W-1:0]  d_reg;
    logic [EW-1:0]              quo     [NE];
    logic                       det_neg;

    assign en        = !vld_reg[LAT] || out_ready;
    assign pop       = en && !fstat.empty;
    assign out_valid = vld_reg[LAT];
    assign out_sing  = sing_reg[LAT];
    assign det_neg   = job.det[mi3_pkg::DET_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-1:0], !fstat.empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= {sing_reg[LAT-1:0], job.det == '0};
            d_reg    <= det_neg ? -job.det : job.det;
            for (int i = 0; i < NE; i++)
            begin
                n_reg[i]   <= {(job.cof[i][CW-1] ? -job.cof[i] : job.cof[i]), {F2{1'b0}}};
                neg_reg[i] <= job.cof[i][CW-1] ^ det_neg;
            end
        end
    end

    for (genvar i = 0; i < NE; i++)
    begin : g_lane
        mi3_div_lane u_lane (
            .clk (clk),
            .en  (en),
            .num (n_reg[i]),
            .den (d_reg),
            .neg (neg_reg[i]),
            .quo (quo[i])
        );
        assign out_data[i*EW +: EW] = sing_reg[LAT]
            ? ((i % 4 == 0) ? mi3_pkg::ONE_VAL : '0) : quo[i];
    end

endmodule

### src/matrix_inverse_3x3_core.sv
// Matrix inverse core: 3x3 Q16.16 inverse by adjugate, streaming in and out.
// One matrix is taken per cycle and one result leaves per cycle when the sink
// keeps up. From input request to result the path runs through four
// front stages (products, cofactors, split determinant products, determinant
// sum), the queue, one sign stage, and the 36 stages of each divider
// lane (range check, 34 quotient bits, rounding and saturation).
// A zero determinant returns the identity with tuser set.
module matrix_inverse_3x3_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
    input  logic [mi3_pkg::DATA_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each)
    output logic [mi3_pkg::DATA_W-1:0]   m_axis_tdata,
    // singular
    output logic [0:0]                   m_axis_tuser
);

    logic                 push, pop;
    mi3_pkg::job_t        wjob, rjob;
    mi3_pkg::fifo_stat_t  fstat;

    mi3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .fstat    (fstat),
        .push     (push),
        .job      (wjob)
    );

    mi3_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wjob),
        .pop   (pop),
        .rdata (rjob),
        .fstat (fstat)
    );

    mi3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (rjob),
        .fstat     (fstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_sing  (m_axis_tuser[0])
    );

    property p_sing_ident;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[mi3_pkg::ENT_W-1:0] == mi3_pkg::ONE_VAL);
    endproperty
    a_sing_ident: assert property (p_sing_ident) else $error("singular without identity");

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");

    property p_front_stall;
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> fstat.full;
    endproperty
    a_front_stall: assert property (p_front_stall) else $error("front stalled with room");

endmodule
